/* sv/clkrep_pkg.sv */
// shared types and constants for the clock-replacement cache tag engine
// no dependencies; imported by every module of the block
package clkrep_pkg;

  // default number of cache slots
  localparam int SLOTS_DEF = 64;
  // width of a disk sector number
  localparam int SECTOR_W  = 32;
  // width of the slot field on the result channel
  localparam int SLOT_W    = 6;

  // request type codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_RES  = 3'b100
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new request beat
    logic compare;  // register the tag match vector
    logic resolve;  // settle hit or victim, update state, emit result
  } dp_cmd_t;

endpackage

/* sv/clkrep_ctrl.sv */
// controller state machine of the clock-replacement cache tag engine
// depends on clkrep_pkg; drives the datapath through a dp_cmd_t bundle
module clkrep_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output clkrep_pkg::dp_cmd_t cmd
);
  import clkrep_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  // a new beat may enter while the previous one resolves
  assign busy   = (state_r == ST_CMP);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        state_nxt = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command outputs
  always_comb begin
    cmd.load    = accept;
    cmd.compare = (state_r == ST_CMP);
    cmd.resolve = (state_r == ST_RES);
  end

endmodule

/* sv/clkrep_dp.sv */
// datapath of the clock-replacement cache tag engine: tag cells, policy bits,
// clock hand, victim search and result registers; depends on clkrep_pkg
module clkrep_dp #(
  parameter int SLOTS = clkrep_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  clkrep_pkg::dp_cmd_t              cmd,
  input  logic                             in_req_type,
  input  logic [clkrep_pkg::SECTOR_W-1:0]  in_sector,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [clkrep_pkg::SLOT_W-1:0]    out_slot,
  output logic                             out_writeback,
  output logic [clkrep_pkg::SECTOR_W-1:0]  out_victim_sector,
  output logic                             out_fill
);
  import clkrep_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  // request registers
  logic                req_type_r;
  logic [SECTOR_W-1:0] sector_r;

  // tag cells and policy bits
  logic [SECTOR_W-1:0] tag_r [SLOTS];
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [SLOTS-1:0]    ref_r, ref_nxt;
  logic [SLOTS-1:0]    dirty_r, dirty_nxt;
  logic [IDX_W-1:0]    hand_r, hand_nxt;
  logic [SLOTS-1:0]    match_r, match_nxt;

  // search results
  logic [IDX_W-1:0]    start_idx;
  logic [SLOTS-1:0]    avail, avail_hi, passed;
  logic [IDX_W-1:0]    hi_idx, all_idx, hit_idx, victim;
  logic                hi_any, all_any, hit_any;
  logic                victim_dirty;

  // result registers
  logic                out_valid_r;
  logic                out_hit_r, out_writeback_r, out_fill_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [SECTOR_W-1:0] out_victim_sector_r;

  // one comparator per slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == sector_r);
    end
  end

  // hand steps forward one slot before the search
  assign start_idx = (hand_r == IDX_W'(SLOTS - 1)) ? '0 : hand_r + 1'b1;
  assign avail     = ~valid_r | ~ref_r;

  // lowest-index priority encoders: hit slot and rotated victim search
  always_comb begin
    hi_idx  = '0;
    all_idx = '0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      avail_hi[i] = avail[i] && (IDX_W'(i) >= start_idx);
      if (avail_hi[i]) hi_idx  = IDX_W'(i);
      if (avail[i])    all_idx = IDX_W'(i);
      if (match_r[i])  hit_idx = IDX_W'(i);
    end
    hi_any  = |avail_hi;
    all_any = |avail;
    hit_any = |match_r;
  end

  // victim falls back to the start slot when every slot is referenced
  assign victim = hi_any ? hi_idx : (all_any ? all_idx : start_idx);

  // slots the hand sweeps past lose their reference bit
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (!all_any) begin
        passed[i] = 1'b1;
      end else if (victim >= start_idx) begin
        passed[i] = (IDX_W'(i) >= start_idx) && (IDX_W'(i) < victim);
      end else begin
        passed[i] = (IDX_W'(i) >= start_idx) || (IDX_W'(i) < victim);
      end
    end
  end

  assign victim_dirty = valid_r[victim] && dirty_r[victim];

  // next policy state
  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    dirty_nxt = dirty_r;
    hand_nxt  = hand_r;
    if (cmd.resolve) begin
      if (hit_any) begin
        ref_nxt[hit_idx] = 1'b1;
        if (req_type_r == REQ_WRITE) dirty_nxt[hit_idx] = 1'b1;
      end else begin
        ref_nxt           = ref_r & ~passed;
        ref_nxt[victim]   = 1'b1;
        valid_nxt[victim] = 1'b1;
        dirty_nxt[victim] = (req_type_r == REQ_WRITE);
        hand_nxt          = victim;
      end
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      hand_r      <= IDX_W'(SLOTS - 1);
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      dirty_r     <= dirty_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= cmd.resolve;
    end
  end

  // request capture, match vector and tag install
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      sector_r   <= in_sector;
    end
    if (cmd.compare) begin
      match_r <= match_nxt;
    end
    if (cmd.resolve && !hit_any) begin
      tag_r[victim] <= sector_r;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_hit_r <= hit_any;
      if (hit_any) begin
        out_slot_r          <= SLOT_W'(hit_idx);
        out_writeback_r     <= 1'b0;
        out_victim_sector_r <= '0;
        out_fill_r          <= 1'b0;
      end else begin
        out_slot_r          <= SLOT_W'(victim);
        out_writeback_r     <= victim_dirty;
        out_victim_sector_r <= victim_dirty ? tag_r[victim] : '0;
        out_fill_r          <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_writeback     = out_writeback_r;
  assign out_victim_sector = out_victim_sector_r;
  assign out_fill          = out_fill_r;

  // a miss always moves the hand onto the installed slot
  a_hand_on_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && !hit_any) |=> (SLOT_W'(hand_r) == out_slot))
    else $error("hand not left on the victim slot");

  // a hit leaves the hand in place
  a_hand_hold_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && hit_any) |=> $stable(hand_r))
    else $error("hand moved on a hit");

  // the installed slot is valid and referenced afterward
  a_install_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resolve |=> (valid_r != '0) && (ref_r != '0))
    else $error("resolved slot not marked valid and referenced");

endmodule

/* sv/clock_replacement_block_cache_tags.sv */
// top level of the clock-replacement cache tag engine
// depends on clkrep_pkg, clkrep_ctrl and clkrep_dp
//
// Tag and replacement-policy engine for a fully associative sector cache.
// Request channel: drive in_req_type and in_sector with start; the beat is
// taken at a rising edge where start is high and busy is low.
// Result channel: one beat per request, shown for exactly one cycle with
// out_valid high: out_hit, out_slot, out_writeback, out_victim_sector and
// out_fill. The receiver has no way to stall it.
// Path: the parallel tag compare is registered into the match vector, then
// the hit and rotated clock-hand victim search updates the policy state and
// loads the result register, which drives the result channel.
// Overlap: busy is high only in the compare cycle, so the next request is
// taken while the previous one resolves. The parallel compare over all tag
// cells is what holds busy high.
// Reset (rst_n low, synchronous) empties every slot, clears the reference
// and dirty bits and parks the clock hand on the last slot; no clearing pass.
module clock_replacement_block_cache_tags #(
  parameter int SLOTS = clkrep_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [clkrep_pkg::SECTOR_W-1:0]  in_sector,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [clkrep_pkg::SLOT_W-1:0]    out_slot,
  output logic                             out_writeback,
  output logic [clkrep_pkg::SECTOR_W-1:0]  out_victim_sector,
  output logic                             out_fill
);
  import clkrep_pkg::*;

  dp_cmd_t cmd;

  // sequencer
  clkrep_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // tags, policy bits and result registers
  clkrep_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_sector         (in_sector),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_writeback     (out_writeback),
    .out_victim_sector (out_victim_sector),
    .out_fill          (out_fill)
  );

  // every accepted beat yields its result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted request produced no result");

  // results never come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // a hit needs neither fill nor write-back
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_fill && !out_writeback))
    else $error("hit with fill or write-back");

  // a write-back only comes with an eviction
  a_wb_with_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback) |-> (out_fill && !out_hit))
    else $error("write-back without a miss");

endmodule
